// ===== hw/rtl/ptmw_pkg.sv =====
//------------------------------------------------------------------------------
// ptmw_pkg
// shared types, constants and command/status structs for the winding block
//------------------------------------------------------------------------------
`default_nettype none
package ptmw_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int MAX_FACES_DEF  = 65536;
   localparam int SUM_BITS       = 18;
   localparam int CSR_ADDR_BITS  = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_TEST_X = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TEST_Y = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TEST_Z = 2'd2;

   typedef struct packed {
      logic load;      // capture a triangle
      logic minors;    // register edge minors and vertex classes
      logic edges;     // register edge classes and split minor-times-z products
      logic prods;     // register the determinant, the sum of the three products
      logic commit;    // update accumulator
   } ctl_cmd_type;

   typedef struct packed {
      logic last;      // captured triangle is the last one
   } ctl_sts_type;
endpackage
`default_nettype wire

// ===== hw/rtl/ptmw_if.sv =====
//------------------------------------------------------------------------------
// ptmw_if
// valid/ready channel carrying a generic payload
//------------------------------------------------------------------------------
`default_nettype none
interface ptmw_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptmw_ctrl.sv =====
//------------------------------------------------------------------------------
// ptmw_ctrl
// sequencer: load, minors, edges, products, commit, then after a last triangle a result beat
//------------------------------------------------------------------------------
`default_nettype none
module ptmw_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      ptmw_pkg::ctl_cmd_type  cmd,
   input  wire ptmw_pkg::ctl_sts_type  sts
);
   import ptmw_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MIN  = 3'd1;
   localparam logic [2:0] ST_EDGE = 3'd2;
   localparam logic [2:0] ST_PROD = 3'd3;
   localparam logic [2:0] ST_COMM = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_MIN;
         end
         ST_MIN: begin
            cmd.minors = 1'b1;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edges = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prods = 1'b1;
            state_in = ST_COMM;
         end
         ST_COMM: begin
            cmd.commit = 1'b1;
            state_in = sts.last ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_one_owner: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept while result pending");
   a_commit_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(cmd.prods)) else $error("commit out of order");
   a_load_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.minors) else $error("load not followed by minors");
endmodule
`default_nettype wire

// ===== hw/rtl/ptmw_dp.sv =====
//------------------------------------------------------------------------------
// ptmw_dp
// exact integer datapath: relative vertices, minors, determinant, accumulator
//------------------------------------------------------------------------------
`default_nettype none
module ptmw_dp #(
   parameter int COORD_BITS = ptmw_pkg::COORD_BITS_DEF,
   parameter int MAX_FACES  = ptmw_pkg::MAX_FACES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptmw_pkg::ctl_cmd_type         cmd,
   output      ptmw_pkg::ctl_sts_type         sts,
   input  wire logic [9*COORD_BITS:0]         req_data,
   input  wire logic                          csr_write,
   input  wire logic [ptmw_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]         csr_data,
   output      logic [ptmw_pkg::SUM_BITS-1:0] sum_out,
   output      logic                          hit_out
);
   import ptmw_pkg::*;

   localparam int RB  = COORD_BITS + 1;      // relative coordinate
   localparam int MB  = 2 * RB + 1;          // 2x2 minor
   localparam int SPL = RB + 1;              // split point of a determinant minor
   localparam int LB  = 2 * RB + 2;          // low minor part times coordinate
   localparam int HB  = 2 * RB;              // high minor part times coordinate
   localparam int TB  = MB + RB + 2;         // sum of three
   localparam logic signed [SUM_BITS:0] MAXS = (SUM_BITS+1)'(MAX_FACES);

   logic signed [COORD_BITS-1:0] test_ff [3];
   logic signed [RB-1:0] v_ff [3][3];
   logic last_ff;
   logic signed [MB-1:0] mn_ff [3][3];  // [edge][plane xy,xz,yz]
   logic signed [MB-1:0] tm_ff [3];     // determinant minors a,b,c
   logic [1:0] cls_ff [3];              // vertex class: 01 pos, 11 neg, 00 zero
   logic signed [2:0] bnd_ff;
   logic deg_ff;
   logic signed [LB-1:0] pl_ff [3];
   logic signed [HB-1:0] ph_ff [3];
   logic signed [SUM_BITS-1:0] sum_ff;
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) test_ff[k] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TEST_X: test_ff[0] <= csr_data;
            CSR_TEST_Y: test_ff[1] <= csr_data;
            CSR_TEST_Z: test_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: relative vertices
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               v_ff[i][k] <= RB'(signed'(req_data[(3*i+k)*COORD_BITS +: COORD_BITS]))
                           - RB'(test_ff[k]);
         last_ff <= req_data[9*COORD_BITS];
      end
   end
   assign sts.last = last_ff;

   function automatic logic signed [MB-1:0] mnr(input logic signed [RB-1:0] a,
      input logic signed [RB-1:0] d, input logic signed [RB-1:0] b,
      input logic signed [RB-1:0] c);
      logic signed [MB-1:0] p, q;
      p = MB'(a) * MB'(d);
      q = MB'(b) * MB'(c);
      return p - q;
   endfunction

   // stage 2: minors and vertex classes
   always_ff @(posedge clock) begin
      if (cmd.minors) begin
         for (int i = 0; i < 3; i++) begin
            mn_ff[i][0] <= mnr(v_ff[i][1], v_ff[(i+1)%3][0], v_ff[i][0], v_ff[(i+1)%3][1]);
            mn_ff[i][1] <= mnr(v_ff[i][2], v_ff[(i+1)%3][0], v_ff[i][0], v_ff[(i+1)%3][2]);
            mn_ff[i][2] <= mnr(v_ff[i][2], v_ff[(i+1)%3][1], v_ff[i][1], v_ff[(i+1)%3][2]);
            if (v_ff[i][0] != 0)      cls_ff[i] <= {v_ff[i][0][RB-1], 1'b1};
            else if (v_ff[i][1] != 0) cls_ff[i] <= {v_ff[i][1][RB-1], 1'b1};
            else if (v_ff[i][2] != 0) cls_ff[i] <= {v_ff[i][2][RB-1], 1'b1};
            else                      cls_ff[i] <= 2'b00;
         end
         tm_ff[0] <= mnr(v_ff[0][0], v_ff[1][1], v_ff[0][1], v_ff[1][0]);
         tm_ff[1] <= mnr(v_ff[1][0], v_ff[2][1], v_ff[1][1], v_ff[2][0]);
         tm_ff[2] <= mnr(v_ff[2][0], v_ff[0][1], v_ff[2][1], v_ff[0][0]);
      end
   end

   // stage 3: edge classes
   logic signed [2:0] bnd_in;
   logic deg_in;
   always_comb begin
      logic signed [2:0] b;
      logic d;
      b = '0;
      d = (cls_ff[0] == 2'b00) || (cls_ff[1] == 2'b00) || (cls_ff[2] == 2'b00);
      for (int i = 0; i < 3; i++) begin
         if (cls_ff[i] != cls_ff[(i+1)%3]) begin
            if (mn_ff[i][0] != 0)      b = b + (mn_ff[i][0][MB-1] ? -3'sd1 : 3'sd1);
            else if (mn_ff[i][1] != 0) b = b + (mn_ff[i][1][MB-1] ? -3'sd1 : 3'sd1);
            else if (mn_ff[i][2] != 0) b = b + (mn_ff[i][2][MB-1] ? -3'sd1 : 3'sd1);
            else                       d = 1'b1;
         end
      end
      bnd_in = b;
      deg_in = d;
   end

   // minor times z split in a low unsigned and a high signed part
   always_ff @(posedge clock) begin
      if (cmd.edges) begin
         bnd_ff <= bnd_in;
         deg_ff <= deg_in;
         for (int i = 0; i < 3; i++) begin
            pl_ff[i] <= LB'(signed'({1'b0, tm_ff[i][SPL-1:0]})) * LB'(v_ff[(i+2)%3][2]);
            ph_ff[i] <= HB'(signed'(tm_ff[i][MB-1:SPL])) * HB'(v_ff[(i+2)%3][2]);
         end
      end
   end

   // stage 4: determinant, whose sign gives the contribution
   logic signed [TB-1:0] det_ff;
   always_ff @(posedge clock) begin
      if (cmd.prods)
         det_ff <= (TB'(ph_ff[0]) <<< SPL) + TB'(pl_ff[0])
                 + (TB'(ph_ff[1]) <<< SPL) + TB'(pl_ff[1])
                 + (TB'(ph_ff[2]) <<< SPL) + TB'(pl_ff[2]);
   end

   logic signed [SUM_BITS:0] nsum;
   logic dg;
   logic signed [1:0] ctb;
   always_comb begin
      ctb = 2'sd0;
      dg = deg_ff;
      if (bnd_ff != 0) begin
         if (det_ff == 0) dg = 1'b1;
         else ctb = det_ff[TB-1] ? -2'sd1 : 2'sd1;
      end
      nsum = (SUM_BITS+1)'(sum_ff) + (SUM_BITS+1)'(ctb);
      if (nsum > MAXS) nsum = MAXS;
      if (nsum < -MAXS) nsum = -MAXS;
   end

   logic signed [SUM_BITS-1:0] osum_ff;
   logic ohit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.commit) begin
         logic h;
         logic signed [SUM_BITS-1:0] s;
         h = hit_ff | dg;
         s = hit_ff ? sum_ff : (dg ? sum_ff : SUM_BITS'(nsum));
         osum_ff <= h ? '0 : s;
         ohit_ff <= h;
         sum_ff <= last_ff ? '0 : s;
         hit_ff <= last_ff ? 1'b0 : h;
      end
   end
   assign sum_out = osum_ff;
   assign hit_out = ohit_ff;

   a_sat: assert property (@(posedge clock) disable iff (reset)
      (sum_ff <= SUM_BITS'(MAX_FACES)) && (sum_ff >= -SUM_BITS'(MAX_FACES)))
      else $error("sum out of range");
   a_hit_frozen: assert property (@(posedge clock) disable iff (reset)
      (hit_ff && !$past(cmd.commit && last_ff)) |-> $stable(sum_ff) || $past(reset))
      else $error("sum moved after surface hit");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && last_ff) |=> (sum_ff == 0 && !hit_ff)) else $error("no clear");
endmodule
`default_nettype wire

// ===== hw/rtl/point_in_triangle_mesh_winding.sv =====
// the last triangle is accepted, then passes the minors, edges, products and commit steps
// before its result beat is valid; the five-step sequencer takes one triangle at a time,
// sharing the minor and determinant registers of the datapath; after a last triangle
// the input also waits in the result beat state until the beat is taken
// reset: synchronous active high; clears sequencer, accumulator, flag and test point
`default_nettype none
module point_in_triangle_mesh_winding #(
   parameter int COORD_BITS = ptmw_pkg::COORD_BITS_DEF,
   parameter int MAX_FACES  = ptmw_pkg::MAX_FACES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ptmw_if.sink      req,
   ptmw_if.source    rsp,
   input  wire logic                                csr_write,
   input  wire logic [ptmw_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]               csr_data
);
   import ptmw_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic [SUM_BITS-1:0] sum;
   logic hit;

   ptmw_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .sts
   );

   ptmw_dp #(.COORD_BITS(COORD_BITS), .MAX_FACES(MAX_FACES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_data(req.data[9*COORD_BITS:0]),
      .csr_write, .csr_index, .csr_data,
      .sum_out(sum), .hit_out(hit)
   );

   assign rsp.data = {hit, sum};
endmodule
`default_nettype wire

// ===== test/tb_point_in_triangle_mesh_winding.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_point_in_triangle_mesh_winding
// Streams triangle meshes into the winding block and checks every result
// beat against an exact integer predictor kept in a small scoreboard.
// Meshes are mostly closed tetrahedra around a moving test point, plus
// stray triangles, broken meshes and surface hits.
//------------------------------------------------------------------------------
module tb_point_in_triangle_mesh_winding;
   import ptmw_pkg::*;

   localparam int CW        = COORD_BITS_DEF;
   localparam int REQ_W     = 9 * CW + 1;
   localparam int RSP_W     = SUM_BITS + 1;
   localparam int SAT_LIMIT = MAX_FACES_DEF;
   localparam int LIMIT     = 3000000;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_NONE = 2'd3;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [127:0]  wide_type;
   typedef struct {
      coord_type p[3][3];
      bit        last;
   } tri_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_ADDR_BITS-1:0] csr_index;
   logic [CW-1:0] csr_data;
   int   errors;
   int   cycles;
   bit   no_gaps;

   ptmw_if #(.W(REQ_W)) req_if ();
   ptmw_if #(.W(RSP_W)) rsp_if ();

   point_in_triangle_mesh_winding u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic int sign_of(input wide_type x);
      if (x < 0) return -1;
      return (x != 0) ? 1 : 0;
   endfunction

   // exact classification of one triangle relative to the test point
   function automatic void triangle_effect(input tri_type t, input coord_type pt[3],
                                           output int contrib, output bit deg);
      wide_type r[3][3];
      wide_type a, b, c, det;
      int cls[3];
      int boundary;
      int s;
      int j;
      deg = 0;
      contrib = 0;
      boundary = 0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            r[i][k] = wide_type'(t.p[i][k]) - wide_type'(pt[k]);
      for (int i = 0; i < 3; i++) begin
         cls[i] = 0;
         for (int k = 2; k >= 0; k--)
            if (r[i][k] != 0) cls[i] = sign_of(r[i][k]);
         if (cls[i] == 0) deg = 1;
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         if (cls[i] != cls[j]) begin
            s = sign_of(r[i][1] * r[j][0] - r[i][0] * r[j][1]);
            if (s == 0) s = sign_of(r[i][2] * r[j][0] - r[i][0] * r[j][2]);
            if (s == 0) s = sign_of(r[i][2] * r[j][1] - r[i][1] * r[j][2]);
            if (s == 0) deg = 1;
            boundary += s;
         end
      end
      if (boundary != 0) begin
         a = r[0][0] * r[1][1] - r[0][1] * r[1][0];
         b = r[1][0] * r[2][1] - r[1][1] * r[2][0];
         c = r[2][0] * r[0][1] - r[2][1] * r[0][0];
         det = a * r[2][2] + b * r[0][2] + c * r[1][2];
         contrib = sign_of(det);
         if (contrib == 0) deg = 1;
      end
   endfunction

   class winding_scoreboard;
      coord_type point[3];
      int     running;
      bit     hit;
      logic [RSP_W-1:0] expected_sums[$];

      task note_input(input tri_type t);
         int c;
         bit d;
         triangle_effect(t, point, c, d);
         if (!hit) begin
            if (d) hit = 1;
            else begin
               running += c;
               if (running > SAT_LIMIT) running = SAT_LIMIT;
               if (running < -SAT_LIMIT) running = -SAT_LIMIT;
            end
         end
         if (t.last) begin
            expected_sums.push_back(hit ? {SUM_BITS'(0), 1'b1}
                                        : {SUM_BITS'(running), 1'b0});
            running = 0;
            hit = 0;
         end
      endtask

      task check_result(input logic [RSP_W-1:0] got);
         logic [RSP_W-1:0] want;
         if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_sums.pop_front();
         if (got[RSP_W-2:0] !== want[RSP_W-1:1])
            report_mismatch($sformatf("winding_twice got %0d want %0d",
               $signed(got[RSP_W-2:0]), $signed(want[RSP_W-1:1])));
         if (got[RSP_W-1] !== want[0])
            report_mismatch($sformatf("on_surface got %b want %b", got[RSP_W-1], want[0]));
      endtask
   endclass

   winding_scoreboard mesh_sb;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_if.valid = 0;
      req_if.data = '0;
      rsp_if.ready = 0;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      cycles = 0;
      no_gaps = 0;
      mesh_sb = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls and checking
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 0;
      else begin
         if (rsp_if.valid && rsp_if.ready) mesh_sb.check_result(rsp_if.data);
         rsp_if.ready <= no_gaps || ($urandom_range(99) >= 34);
      end
   end

   task automatic drive_triangle(input tri_type t);
      while (!no_gaps && $urandom_range(99) < 34) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.data <= {t.last, t.p[2][2], t.p[2][1], t.p[2][0], t.p[1][2], t.p[1][1],
                      t.p[1][0], t.p[0][2], t.p[0][1], t.p[0][0]};
      do @(posedge clock); while (!req_if.ready);
      mesh_sb.note_input(t);
   endtask

   task automatic set_point(input coord_type x, input coord_type y, input coord_type z);
      coord_type vals[3];
      req_if.valid <= 0;
      while (mesh_sb.expected_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      vals[0] = x; vals[1] = y; vals[2] = z;
      for (int i = 0; i < 3; i++) begin
         csr_write <= 1;
         csr_index <= CSR_ADDR_BITS'(i);
         csr_data <= vals[i];
         @(posedge clock);
         mesh_sb.point[i] = vals[i];
      end
      // out-of-range index must be ignored
      csr_index <= CSR_NONE;
      csr_data <= coord_type'($urandom);
      @(posedge clock);
      csr_write <= 0;
   endtask

   function automatic tri_type make_tri(input coord_type a[3], input coord_type b[3],
                                        input coord_type c[3], input bit last);
      tri_type t;
      for (int k = 0; k < 3; k++) begin
         t.p[0][k] = a[k]; t.p[1][k] = b[k]; t.p[2][k] = c[k];
      end
      t.last = last;
      return t;
   endfunction

   // closed tetrahedron, optionally with one face dropped
   task automatic send_tetra(input coord_type v[4][3], input bit broken);
      int faces[4][3] = '{'{0, 1, 2}, '{0, 2, 3}, '{0, 3, 1}, '{1, 3, 2}};
      int skip;
      int n;
      skip = broken ? $urandom_range(3) : 4;
      n = broken ? 3 : 4;
      for (int f = 0; f < 4; f++)
         if (f != skip) begin
            n--;
            drive_triangle(make_tri(v[faces[f][0]], v[faces[f][1]], v[faces[f][2]],
                                    n == 0));
         end
   endtask

   function automatic coord_type near_coord(input coord_type base, input int span);
      return base + coord_type'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   initial begin
      coord_type tv[4][3];
      coord_type a[3], b[3], c[3];
      int kind, span, count;
      int items;

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed meshes around the origin
      set_point(0, 0, 0);
      a = '{CMAX, CMIN, CMAX}; b = '{CMIN, CMAX, CMIN}; c = '{CMAX, CMAX, CMIN};
      drive_triangle(make_tri(a, b, c, 1));
      a = '{0, 0, 0}; b = '{5, 1, 2}; c = '{3, -4, 7};
      drive_triangle(make_tri(a, b, c, 1));
      // edge passing through the point
      a = '{-3, -3, -3}; b = '{5, 5, 5}; c = '{1, 2, 9};
      drive_triangle(make_tri(a, b, c, 1));
      // triangle in a plane through the point
      a = '{-1, 2, 0}; b = '{3, -1, 0}; c = '{2, 5, 0};
      drive_triangle(make_tri(a, b, c, 1));
      // all vertices on one side: no edge is examined
      a = '{1, 1, 1}; b = '{2, 3, 4}; c = '{5, 0, -1};
      drive_triangle(make_tri(a, b, c, 0));
      tv = '{'{-10, -10, -10}, '{20, -10, -10}, '{-10, 20, -10}, '{-10, -10, 20}};
      send_tetra(tv, 0);
      // surface hit first, then contributions are ignored
      a = '{0, 0, 0}; b = '{5, 1, 2}; c = '{3, -4, 7};
      drive_triangle(make_tri(a, b, c, 0));
      send_tetra(tv, 0);
      // point at the extremes
      set_point(CMAX, CMIN, CMAX);
      drive_triangle(make_tri('{CMIN, CMAX, CMIN}, '{CMAX, CMAX, CMAX},
                              '{CMIN, CMIN, CMIN}, 1));
      tv = '{'{CMAX, CMIN, CMAX}, '{CMIN, CMAX, CMIN}, '{CMIN, CMIN, CMIN},
             '{CMAX, CMAX, CMAX}};
      send_tetra(tv, 0);
      set_point(CMIN, CMAX, CMIN);
      tv = '{'{CMAX, CMIN, CMAX}, '{CMIN, CMAX, CMIN}, '{CMIN, CMIN, CMIN},
             '{CMAX, CMAX, CMAX}};
      send_tetra(tv, 0);

      // random meshes
      items = 0;
      while (items < 450) begin
         if ($urandom_range(7) == 0)
            set_point(any_coord(), any_coord(), any_coord());
         no_gaps = (items >= 150 && items < 260);
         kind = $urandom_range(99);
         span = ($urandom_range(3) == 0) ? 4 : 3000;
         if (kind < 75) begin
            for (int i = 0; i < 4; i++)
               for (int k = 0; k < 3; k++)
                  tv[i][k] = ($urandom_range(9) == 0) ? any_coord()
                           : near_coord(mesh_sb.point[k], span);
            send_tetra(tv, kind >= 62);
            items += 4;
         end else begin
            count = $urandom_range(1, 6);
            for (int n = 0; n < count; n++) begin
               for (int k = 0; k < 3; k++) begin
                  a[k] = near_coord(mesh_sb.point[k], span);
                  b[k] = ($urandom_range(1)) ? any_coord() : near_coord(mesh_sb.point[k], span);
                  c[k] = near_coord(mesh_sb.point[k], span);
               end
               drive_triangle(make_tri(a, b, c, n == count - 1));
            end
            items += count;
         end
      end
      no_gaps = 0;

      req_if.valid <= 0;
      while (mesh_sb.expected_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
